// ===== rtl/core/pid_tustin_filtered_derivative_top_assert.svh =====
// assertion macros used by the pid controller top level
`ifndef PID_TUSTIN_FILTERED_DERIVATIVE_TOP_ASSERT_SVH
`define PID_TUSTIN_FILTERED_DERIVATIVE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PIDTF_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("pid controller: implication check failed");
// next-cycle implication
`define PIDTF_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("pid controller: next-cycle check failed");
`else
`define PIDTF_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define PIDTF_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== rtl/core/pidtf_pkg.sv =====
// shared types, constants, helpers and microprogram of the pid controller
package pidtf_pkg;

  // data formats
  localparam int DW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int GAIN_W    = 31;
  localparam int OPND_W    = DW + 1;
  localparam int PROD_W    = 2 * DW;
  localparam int WIDE_W    = 2 * OPND_W;
  localparam int DIV_BITS  = DW;
  localparam int CNT_W     = $clog2(DIV_BITS);
  localparam int PC_W      = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = ~SMAX;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TC     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH    = 3'd6;

  // register reset values
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 31'd65536;
  localparam logic [GAIN_W-1:0] RST_INTEGRAL_GAIN = 31'd0;
  localparam logic [GAIN_W-1:0] RST_DERIV_GAIN    = 31'd0;
  localparam logic [GAIN_W-1:0] RST_SAMPLE_PERIOD = 31'd66;
  localparam logic [GAIN_W-1:0] RST_FILTER_TC     = 31'd655;
  localparam logic signed [DW-1:0] RST_LIMIT_LOW  = SMIN;
  localparam logic signed [DW-1:0] RST_LIMIT_HIGH = SMAX;

  // datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_MUL_P    = 4'd2;
  localparam logic [3:0] OP_MUL_KITS = 4'd3;
  localparam logic [3:0] OP_KITS     = 4'd4;
  localparam logic [3:0] OP_MUL_INC  = 4'd5;
  localparam logic [3:0] OP_MUL_P1   = 4'd6;
  localparam logic [3:0] OP_MUL_P2   = 4'd7;
  localparam logic [3:0] OP_DIFF     = 4'd8;
  localparam logic [3:0] OP_DIV_INIT = 4'd9;
  localparam logic [3:0] OP_DIV_STEP = 4'd10;
  localparam logic [3:0] OP_DFILT    = 4'd11;
  localparam logic [3:0] OP_SUM      = 4'd12;
  localparam logic [3:0] OP_CLEAR    = 4'd13;

  // jump conditions
  localparam logic [1:0] JC_NONE  = 2'd0;
  localparam logic [1:0] JC_CLEAR = 2'd1;
  localparam logic [1:0] JC_SKIP  = 2'd2;
  localparam logic [1:0] JC_LOOP  = 2'd3;

  // program addresses
  localparam logic [PC_W-1:0] PC_LOAD     = 4'd0;
  localparam logic [PC_W-1:0] PC_MUL_P    = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_KITS = 4'd2;
  localparam logic [PC_W-1:0] PC_KITS     = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL_INC  = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL_P1   = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_P2   = 4'd6;
  localparam logic [PC_W-1:0] PC_DIFF     = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd8;
  localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd9;
  localparam logic [PC_W-1:0] PC_DFILT    = 4'd10;
  localparam logic [PC_W-1:0] PC_SUM      = 4'd11;
  localparam logic [PC_W-1:0] PC_CLEAR    = 4'd12;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] sample_period;
    logic [GAIN_W-1:0] filter_tc;
    logic [DW-1:0]     limit_low;
    logic [DW-1:0]     limit_high;
  } cfg_t;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      jc;
    logic [PC_W-1:0] tgt;
    logic            ld_cnt;
    logic            last;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic       en;
    logic       emit;
    logic [3:0] op;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic clr;
    logic skip;
  } stat_t;

  // saturate a wide signed value to the data width
  function automatic logic signed [DW-1:0] sat_w(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(SMAX);
    lo = WIDE_W'(SMIN);
    if (x > hi) begin
      sat_w = SMAX;
    end else if (x < lo) begin
      sat_w = SMIN;
    end else begin
      sat_w = x[DW-1:0];
    end
  endfunction

  // clamp to the limits, upper test first
  function automatic logic signed [DW-1:0] clamp_lim(input logic signed [DW-1:0] x,
                                                     input logic signed [DW-1:0] lo,
                                                     input logic signed [DW-1:0] hi);
    if (x > hi) begin
      clamp_lim = hi;
    end else if (x < lo) begin
      clamp_lim = lo;
    end else begin
      clamp_lim = x;
    end
  endfunction

  // microprogram rom
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, jc: JC_NONE, tgt: PC_LOAD, ld_cnt: 1'b0, last: 1'b0};
    unique case (pc)
      PC_LOAD:     w = '{OP_LOAD,     JC_CLEAR, PC_CLEAR,    1'b0, 1'b0};
      PC_MUL_P:    w = '{OP_MUL_P,    JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_MUL_KITS: w = '{OP_MUL_KITS, JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_KITS:     w = '{OP_KITS,     JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_MUL_INC:  w = '{OP_MUL_INC,  JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_MUL_P1:   w = '{OP_MUL_P1,   JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_MUL_P2:   w = '{OP_MUL_P2,   JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_DIFF:     w = '{OP_DIFF,     JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_DIV_INIT: w = '{OP_DIV_INIT, JC_SKIP,  PC_DFILT,    1'b1, 1'b0};
      PC_DIV_STEP: w = '{OP_DIV_STEP, JC_LOOP,  PC_DIV_STEP, 1'b0, 1'b0};
      PC_DFILT:    w = '{OP_DFILT,    JC_NONE,  PC_LOAD,     1'b0, 1'b0};
      PC_SUM:      w = '{OP_SUM,      JC_NONE,  PC_LOAD,     1'b0, 1'b1};
      PC_CLEAR:    w = '{OP_CLEAR,    JC_NONE,  PC_LOAD,     1'b0, 1'b1};
      // unused addresses end the program
      default:     w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/pidtf_seq.sv =====
// microcode sequencer: step counter, loop counter and conditional jumps
module pidtf_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             out_free,
  input  pidtf_pkg::stat_t stat,
  output pidtf_pkg::ctrl_t ctrl,
  output logic             busy
);
  import pidtf_pkg::*;

  logic            busy_r;
  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [CNT_W-1:0] cnt_r;
  ucode_t          uw;
  logic            take;
  logic            run;

  // fetch the current control word
  assign uw = ucode(pc_r);

  // the final step waits for a free result slot
  assign run  = busy_r && !(uw.last && !out_free);
  assign busy = busy_r;

  assign ctrl.en   = run;
  assign ctrl.emit = run && uw.last;
  assign ctrl.op   = uw.op;

  // jump condition decode
  always_comb begin
    unique case (uw.jc)
      JC_NONE:  take = 1'b0;
      JC_CLEAR: take = stat.clr;
      JC_SKIP:  take = stat.skip;
      JC_LOOP:  take = (cnt_r != '0);
      default:  take = 1'b0;
    endcase
  end

  assign pc_nxt = take ? uw.tgt : pc_r + 1'b1;

  // step counter and loop counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_LOAD;
      cnt_r  <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      pc_r   <= PC_LOAD;
    end else if (run) begin
      if (uw.last) begin
        busy_r <= 1'b0;
      end else begin
        pc_r <= pc_nxt;
      end
      if (uw.ld_cnt) begin
        cnt_r <= CNT_W'(DIV_BITS - 1);
      end else if (uw.jc == JC_LOOP && cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pidtf_dp.sv =====
// datapath: shared multiplier, radix-2 divider, saturation and controller state
module pidtf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        in_req_type,
  input  logic signed [pidtf_pkg::DW-1:0] in_target,
  input  logic signed [pidtf_pkg::DW-1:0] in_measured,
  input  pidtf_pkg::cfg_t             cfg,
  input  pidtf_pkg::ctrl_t            ctrl,
  output pidtf_pkg::stat_t            stat,
  output logic signed [pidtf_pkg::DW-1:0] drive
);
  import pidtf_pkg::*;

  // captured request
  logic                     req_r;
  logic signed [DW-1:0]     tgt_r;
  logic signed [DW-1:0]     meas_r;

  // controller state
  logic signed [DW-1:0]     integ_r;
  logic signed [DW-1:0]     df_r;
  logic signed [DW-1:0]     last_err_r;
  logic signed [DW-1:0]     last_meas_r;

  // working registers
  logic signed [DW-1:0]     err_r;
  logic signed [DW-1:0]     dm_r;
  logic signed [OPND_W-1:0] esum_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DW-1:0]     p_r;
  logic [GAIN_W-1:0]        kits_r;
  logic signed [PROD_W-1:0] p1_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        mag_r;
  logic                     zero_r;
  logic                     big_r;
  logic [OPND_W-1:0]        rem_r;
  logic [DW-1:0]            quo_r;

  // combinational values
  logic signed [OPND_W-1:0] a_coef;
  logic [OPND_W-1:0]        b_den;
  logic signed [OPND_W-1:0] mul_a;
  logic signed [OPND_W-1:0] mul_b;
  logic                     mul_sel;
  logic signed [WIDE_W-1:0] mul_full;
  logic signed [DW-1:0]     err_nxt;
  logic signed [DW-1:0]     dm_nxt;
  logic signed [DW-1:0]     shr_sat;
  logic signed [DW-1:0]     inc;
  logic signed [DW-1:0]     integ_nxt;
  logic signed [PROD_W-1:0] p2;
  logic                     neg_nxt;
  logic [PROD_W-1:0]        mag_nxt;
  logic                     big_nxt;
  logic [OPND_W+1:0]        trial;
  logic signed [DW-1:0]     df_nxt;
  logic signed [DW-1:0]     drive_nxt;
  logic signed [DW-1:0]     lim_lo;
  logic signed [DW-1:0]     lim_hi;

  assign lim_lo = $signed(cfg.limit_low);
  assign lim_hi = $signed(cfg.limit_high);

  // filter coefficients 2*tau - ts and 2*tau + ts
  assign a_coef = $signed({1'b0, cfg.filter_tc, 1'b0}) - $signed({2'b00, cfg.sample_period});
  assign b_den  = {1'b0, cfg.filter_tc, 1'b0} + {2'b00, cfg.sample_period};

  // multiplier operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sel = 1'b1;
    case (ctrl.op)
      OP_MUL_P: begin
        mul_a = $signed({2'b00, cfg.prop_gain});
        mul_b = OPND_W'(err_r);
      end
      OP_MUL_KITS: begin
        mul_a = $signed({2'b00, cfg.integral_gain});
        mul_b = $signed({2'b00, cfg.sample_period});
      end
      OP_MUL_INC: begin
        mul_a = $signed({2'b00, kits_r});
        mul_b = esum_r;
      end
      OP_MUL_P1: begin
        mul_a = a_coef;
        mul_b = OPND_W'(df_r);
      end
      OP_MUL_P2: begin
        mul_a = $signed({2'b00, cfg.deriv_gain});
        mul_b = OPND_W'(dm_r);
      end
      default: mul_sel = 1'b0;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // error and measurement step
  assign err_nxt = sat_w(WIDE_W'(tgt_r) - WIDE_W'(meas_r));
  assign dm_nxt  = sat_w(WIDE_W'(meas_r) - WIDE_W'(last_meas_r));

  // product rescale, floor rounding
  assign shr_sat = sat_w(WIDE_W'(prod_r >>> FRAC_BITS));
  assign inc     = sat_w(WIDE_W'(prod_r >>> (FRAC_BITS + 1)));

  // trapezoid integrator with clamp
  assign integ_nxt = clamp_lim(sat_w(WIDE_W'(integ_r) + WIDE_W'(inc)), lim_lo, lim_hi);

  // filter numerator sign and magnitude
  assign p2      = prod_r <<< 1;
  assign neg_nxt = p1_r < p2;
  assign mag_nxt = neg_nxt ? PROD_W'(p2 - p1_r) : PROD_W'(p1_r - p2);

  // quotient overflows the data width or the denominator is zero
  assign big_nxt = {1'b0, mag_r[PROD_W-1:DW]} >= b_den;

  // restoring division trial subtract
  assign trial = {1'b0, rem_r, quo_r[DW-1]} - {2'b00, b_den};

  // filter output with saturation
  always_comb begin
    if (zero_r) begin
      df_nxt = '0;
    end else if (big_r || quo_r[DW-1]) begin
      df_nxt = neg_r ? SMIN : SMAX;
    end else if (neg_r) begin
      df_nxt = -$signed(quo_r);
    end else begin
      df_nxt = $signed(quo_r);
    end
  end

  // p + i + d, saturated and clamped
  assign drive_nxt = clamp_lim(sat_w(WIDE_W'(p_r) + WIDE_W'(integ_r) + WIDE_W'(df_r)),
                               lim_lo, lim_hi);

  assign drive     = (ctrl.op == OP_CLEAR) ? '0 : drive_nxt;
  assign stat.clr  = req_r;
  assign stat.skip = big_nxt;

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      tgt_r  <= in_target;
      meas_r <= in_measured;
    end
  end

  // controller state kept between requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      df_r        <= '0;
      last_err_r  <= '0;
      last_meas_r <= '0;
    end else if (ctrl.en) begin
      case (ctrl.op)
        OP_MUL_P1: integ_r <= integ_nxt;
        OP_DFILT:  df_r    <= df_nxt;
        OP_SUM: begin
          last_err_r  <= err_r;
          last_meas_r <= meas_r;
        end
        OP_CLEAR: begin
          integ_r     <= '0;
          df_r        <= '0;
          last_err_r  <= '0;
          last_meas_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // shared product register
  always_ff @(posedge clk) begin
    if (ctrl.en && mul_sel) begin
      prod_r <= mul_full[PROD_W-1:0];
    end
  end

  // working registers per step
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.op)
        OP_LOAD: begin
          err_r <= err_nxt;
          dm_r  <= dm_nxt;
        end
        OP_MUL_P:    esum_r <= OPND_W'(err_r) + OPND_W'(last_err_r);
        OP_MUL_KITS: p_r    <= shr_sat;
        OP_KITS:     kits_r <= shr_sat[GAIN_W-1:0];
        OP_MUL_P2:   p1_r   <= prod_r;
        OP_DIFF: begin
          neg_r <= neg_nxt;
          mag_r <= mag_nxt;
        end
        OP_DIV_INIT: begin
          zero_r <= (b_den == '0);
          big_r  <= big_nxt;
          rem_r  <= {1'b0, mag_r[PROD_W-1:DW]};
          quo_r  <= mag_r[DW-1:0];
        end
        OP_DIV_STEP: begin
          if (!trial[OPND_W+1]) begin
            rem_r <= trial[OPND_W-1:0];
            quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[OPND_W-2:0], quo_r[DW-1]};
            quo_r <= {quo_r[DW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pid_tustin_filtered_derivative_top.sv =====
// Top level of a Q16.16 PID controller with trapezoid integrator, filtered derivative on
// the measurement and output clamping. An update request runs a 13-step microprogram, one
// control word per cycle, the last step waiting for a free result slot, over a single
// shared 33x33 multiplier and a one-bit-per-cycle restoring divider for the derivative
// filter. When the filter quotient is known to saturate, or the filter denominator is
// zero, the divider is skipped. A clear request runs only the load and clear steps. A new
// request is accepted in the cycle after the result is loaded into the output register,
// even while that result waits to be taken. The user must write configuration registers
// through the cfg port only while the block is idle; the block does not enforce it.
`include "pid_tustin_filtered_derivative_top_assert.svh"

module pid_tustin_filtered_derivative_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic signed [pidtf_pkg::DW-1:0]      in_target,
  input  logic signed [pidtf_pkg::DW-1:0]      in_measured,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidtf_pkg::DW-1:0]      out_drive,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [pidtf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidtf_pkg::DW-1:0]             cfg_data
);
  import pidtf_pkg::*;

  cfg_t                 cfg_r;
  logic                 out_valid_r;
  logic signed [DW-1:0] out_drive_r;
  logic                 busy;
  logic                 accept;
  logic                 out_free;
  logic                 emit;
  ctrl_t                ctrl;
  stat_t                stat;
  logic signed [DW-1:0] drive;

  // handshakes
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = ctrl.emit;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= RST_PROP_GAIN;
      cfg_r.integral_gain <= RST_INTEGRAL_GAIN;
      cfg_r.deriv_gain    <= RST_DERIV_GAIN;
      cfg_r.sample_period <= RST_SAMPLE_PERIOD;
      cfg_r.filter_tc     <= RST_FILTER_TC;
      cfg_r.limit_low     <= RST_LIMIT_LOW;
      cfg_r.limit_high    <= RST_LIMIT_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN: cfg_r.integral_gain <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:    cfg_r.deriv_gain    <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_data[GAIN_W-1:0];
        REG_FILTER_TC:     cfg_r.filter_tc     <= cfg_data[GAIN_W-1:0];
        REG_LIMIT_LOW:     cfg_r.limit_low     <= cfg_data;
        REG_LIMIT_HIGH:    cfg_r.limit_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_drive_r <= drive;
    end
  end

  // microcode sequencer
  pidtf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  // arithmetic datapath
  pidtf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_req_type (in_req_type),
    .in_target   (in_target),
    .in_measured (in_measured),
    .cfg         (cfg_r),
    .ctrl        (ctrl),
    .stat        (stat),
    .drive       (drive)
  );

  // a result is only loaded into a free output slot
  `PIDTF_ASSERT_IMP(a_emit_slot_free, clk, rst_n, emit, !out_valid_r || !out_stall)
  // an accepted request keeps the sequencer busy next cycle
  `PIDTF_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
  // a result appears only after the sequencer finished a program
  `PIDTF_ASSERT_IMP(a_out_from_emit, clk, rst_n, $rose(out_valid_r), $past(emit))

endmodule

// ===== test/pid_tustin_filtered_derivative_top_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the q16.16 pid controller with filtered derivative
module pid_tustin_filtered_derivative_top_test;
  import pidtf_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_mode_t;

  localparam wide_t WORD_MAX    = 128'sd2147483647;
  localparam wide_t WORD_MIN    = -128'sd2147483648;
  localparam logic  REQ_UPDATE  = 1'b0;
  localparam logic  REQ_CLEAR   = 1'b1;
  localparam int    CYCLE_LIMIT = 1000000;
  localparam int    PRINT_LIMIT = 100;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_req_type;
  logic signed [DW-1:0]    in_target;
  logic signed [DW-1:0]    in_measured;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DW-1:0]    out_drive;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [DW-1:0]           cfg_data;

  // predictor copy of registers and controller state
  wide_t kp, ki, kd, ts, tau, lim_lo, lim_hi;
  wide_t integ, dfilt, prev_err, prev_meas;

  logic signed [DW-1:0] expected_drive [$];
  int mismatch_count = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  int flow_span = 0;
  flow_mode_t flow_mode = FLOW_FREE;

  pid_tustin_filtered_derivative_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_target   (in_target),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  task automatic report_fail(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch: %s", msg);
    end
    mismatch_count++;
  endtask

  function automatic wide_t sat_word(input wide_t x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // upper bound is tested first so crossed limits resolve the same way as the block
  function automatic wide_t limit_clamp(input wide_t x);
    if (x > lim_hi) return lim_hi;
    if (x < lim_lo) return lim_lo;
    return x;
  endfunction

  task automatic load_reset_model();
    kp = RST_PROP_GAIN;
    ki = RST_INTEGRAL_GAIN;
    kd = RST_DERIV_GAIN;
    ts = RST_SAMPLE_PERIOD;
    tau = RST_FILTER_TC;
    lim_lo = RST_LIMIT_LOW;
    lim_hi = RST_LIMIT_HIGH;
    integ = 0;
    dfilt = 0;
    prev_err = 0;
    prev_meas = 0;
  endtask

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DW-1:0] data);
    logic signed [DW-1:0] sdata;
    sdata = data;
    case (idx)
      REG_PROP_GAIN:     kp = data[GAIN_W-1:0];
      REG_INTEGRAL_GAIN: ki = data[GAIN_W-1:0];
      REG_DERIV_GAIN:    kd = data[GAIN_W-1:0];
      REG_SAMPLE_PERIOD: ts = data[GAIN_W-1:0];
      REG_FILTER_TC:     tau = data[GAIN_W-1:0];
      REG_LIMIT_LOW:     lim_lo = sdata;
      REG_LIMIT_HIGH:    lim_hi = sdata;
      default: ;
    endcase
  endfunction

  // one controller step: proportional, trapezoid integral, filtered derivative
  function automatic logic signed [DW-1:0] next_drive(input logic kind,
                                                      input logic signed [DW-1:0] tgt,
                                                      input logic signed [DW-1:0] meas_in);
    wide_t t, m, err, pterm, kits, inc, dm, a, b, p1, p2, diff, q, drive;
    t = tgt;
    m = meas_in;
    if (kind == REQ_CLEAR) begin
      integ = 0;
      dfilt = 0;
      prev_err = 0;
      prev_meas = 0;
      return '0;
    end
    err = sat_word(t - m);
    pterm = sat_word((kp * err) >>> FRAC_BITS);
    kits = sat_word((ki * ts) >>> FRAC_BITS);
    inc = sat_word((kits * (err + prev_err)) >>> (FRAC_BITS + 1));
    integ = limit_clamp(sat_word(integ + inc));
    // derivative on measurement through the low-pass filter
    dm = sat_word(m - prev_meas);
    a = 2 * tau - ts;
    b = 2 * tau + ts;
    p1 = a * dfilt;
    p2 = 2 * kd * dm;
    if (b == 0) begin
      dfilt = 0;
    end else begin
      diff = p1 - p2;
      q = (diff < 0 ? -diff : diff) / b;
      dfilt = sat_word(diff < 0 ? -q : q);
    end
    drive = limit_clamp(sat_word(pterm + integ + dfilt));
    prev_err = err;
    prev_meas = m;
    return drive[DW-1:0];
  endfunction

  // scoreboard: check results, track register writes, predict accepted requests
  always @(posedge clk) begin : scoreboard
    logic signed [DW-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          report_fail($sformatf("drive %0d with no request outstanding", out_drive));
        end else begin
          want = expected_drive.pop_front();
          if (out_drive !== want) begin
            report_fail($sformatf("drive got %0d expected %0d", out_drive, want));
          end
        end
      end
      if (cfg_we) begin
        apply_register(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        expected_drive.push_back(next_drive(in_req_type, in_target, in_measured));
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(negedge clk) begin
    if (flow_span == 0) begin
      flow_mode = flow_mode_t'($urandom_range(0, 3));
      flow_span = $urandom_range(20, 300);
    end else begin
      flow_span--;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:    out_stall <= ~out_stall;
      endcase
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("pid_tustin_filtered_derivative_top verification failed");
    $finish;
  end

  // sends one request in bursts with random gaps; entered and left at a falling edge
  task automatic send_request(input logic kind, input logic signed [DW-1:0] tgt,
                              input logic signed [DW-1:0] meas);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4))
        @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_req_type <= kind;
    in_target <= tgt;
    in_measured <= meas;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // sender pauses until every outstanding drive value has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_drive.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [DW-1:0] kp_w, ki_w, kd_w, ts_w, tau_w, lo_w, hi_w);
    write_reg(REG_PROP_GAIN, kp_w);
    write_reg(REG_INTEGRAL_GAIN, ki_w);
    write_reg(REG_DERIV_GAIN, kd_w);
    write_reg(REG_SAMPLE_PERIOD, ts_w);
    write_reg(REG_FILTER_TC, tau_w);
    write_reg(REG_LIMIT_LOW, lo_w);
    write_reg(REG_LIMIT_HIGH, hi_w);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [DW-1:0] extreme_word();
    case ($urandom_range(0, 4))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // gain with the unused top bit set at random
  function automatic logic [DW-1:0] pick_gain();
    logic [DW-1:0] v;
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = 32'h0001_0000;
      2: v = $urandom_range(0, 32'h0004_0000);
      3: v = $urandom;
      default: v = 32'h7fff_ffff;
    endcase
    v[DW-1] = $urandom_range(0, 1);
    return v;
  endfunction

  function automatic logic [DW-1:0] pick_period();
    logic [DW-1:0] v;
    case ($urandom_range(0, 4))
      0: v = 1;
      1: v = 66;
      2: v = $urandom_range(1, 32'h0001_0000);
      3: v = $urandom_range(1, 32'h7fff_ffff);
      default: v = 32'h7fff_ffff;
    endcase
    v[DW-1] = $urandom_range(0, 1);
    return v;
  endfunction

  function automatic logic [DW-1:0] pick_tau();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 655;
      2: return $urandom_range(0, 32'h0002_0000);
      3: return $urandom;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic random_config();
    logic signed [DW-1:0] lo, hi;
    case ($urandom_range(0, 4))
      0: begin lo = SMIN; hi = SMAX; end
      1: begin
        lo = -$signed($urandom_range(0, 32'h7fff_ffff));
        hi = $urandom_range(0, 32'h7fff_ffff);
      end
      2: begin
        lo = $urandom_range(1, 32'h0100_0000);
        hi = -$signed($urandom_range(1, 32'h0100_0000));
      end
      3: begin
        lo = -$signed($urandom_range(1, 32'h0100_0000));
        hi = $urandom_range(1, 32'h0100_0000);
      end
      default: begin lo = $urandom; hi = lo; end
    endcase
    set_config(pick_gain(), pick_gain(), pick_gain(), pick_period(), pick_tau(), lo, hi);
  endtask

  // mostly tracking-style updates near the setpoint, some wild values and clears
  task automatic send_random_request();
    logic signed [DW-1:0] t, m;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      send_request(REQ_CLEAR, $urandom, $urandom);
    end else if (sel < 70) begin
      t = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      m = t + int'($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000;
      send_request(REQ_UPDATE, t, m);
    end else if (sel < 90) begin
      send_request(REQ_UPDATE, $urandom, $urandom);
    end else begin
      send_request(REQ_UPDATE, extreme_word(), extreme_word());
    end
  endtask

  // proportional path only, under the register reset values
  task automatic test_reset_values();
    send_request(REQ_UPDATE, 0, 0);
    send_request(REQ_UPDATE, SMAX, SMIN);
    send_request(REQ_UPDATE, SMIN, SMAX);
    send_request(REQ_UPDATE, 32'sh0064_0000, 0);
    send_request(REQ_CLEAR, SMAX, SMAX);
    send_request(REQ_UPDATE, -1, 1);
    wait_drain();
  endtask

  task automatic test_directed_cases();
    // ramp then clear, integral gain written with its unused top bit set
    set_config(32'h0002_0000, 32'h8000_8000, 32'h0000_4000, 32'h0000_1000, 32'h0000_0800,
               -32'sd6553600, 32'sd6553600);
    send_request(REQ_UPDATE, 32'sh0010_0000, 0);
    send_request(REQ_UPDATE, 32'sh0010_0000, 32'sh0004_0000);
    send_request(REQ_UPDATE, 32'sh0010_0000, 32'sh0008_0000);
    send_request(REQ_UPDATE, 32'sh0010_0000, 32'sh000c_0000);
    send_request(REQ_CLEAR, 0, 0);
    send_request(REQ_UPDATE, -32'sh0010_0000, 32'sh0001_0000);
    wait_drain();
    // crossed limits: low above high
    set_config(32'h0001_0000, 0, 0, 66, 655, 32'sd655360, -32'sd655360);
    send_request(REQ_UPDATE, 32'sh0100_0000, 0);
    send_request(REQ_UPDATE, -32'sh0100_0000, 0);
    send_request(REQ_UPDATE, 0, 0);
    wait_drain();
    // zero filter denominator
    set_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, SMIN, SMAX);
    send_request(REQ_UPDATE, 0, 32'sh0001_0000);
    send_request(REQ_UPDATE, 0, -32'sh0003_0000);
    send_request(REQ_UPDATE, 32'sh0002_0000, 0);
    wait_drain();
    // every gain at its maximum
    set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               SMIN, SMAX);
    send_request(REQ_UPDATE, SMAX, SMIN);
    send_request(REQ_UPDATE, SMIN, SMAX);
    send_request(REQ_UPDATE, SMAX, SMAX);
    wait_drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 11; phase++) begin
      if (phase == 0) begin
        set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   SMIN, SMAX);
      end else if (phase == 1) begin
        set_config(0, 0, 0, 1, 0, SMIN, SMAX);
      end else begin
        random_config();
      end
      for (int n = 0; n < 150; n++) begin
        send_random_request();
        if ($urandom_range(0, 49) == 0) wait_drain();
      end
      wait_drain();
    end
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_holdoff();
    set_config(32'h0001_8000, 32'h0000_4000, 32'h0000_2000, 32'h0000_0400, 32'h0000_1000,
               -32'sd3276800, 32'sd3276800);
    hold_cycles = 400;
    burst_left = 1000;
    for (int n = 0; n < 8; n++) begin
      send_random_request();
    end
    wait_drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_UPDATE;
    in_target = '0;
    in_measured = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PROP_GAIN;
    cfg_data = '0;
    load_reset_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_cases();
    test_random_settings();
    test_output_holdoff();

    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pid_tustin_filtered_derivative_top verification clean");
    end else begin
      $display("pid_tustin_filtered_derivative_top verification failed");
    end
    $finish;
  end

endmodule
